// ----- design/lsct_pkg.sv -----
// ----------------------------------------------------------------------------
// lsct_pkg
// shared types, character codes and tag tables for the log clean and tag unit
// ----------------------------------------------------------------------------
package lsct_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned LevelW = 3;
  localparam int unsigned NodeW  = 6;
  localparam int unsigned GroupW = 5;
  localparam int unsigned NumTags = 8;
  localparam int unsigned TagMaxW = 8;

  localparam logic [ByteW-1:0] CHAR_TAB      = 8'h09;
  localparam logic [ByteW-1:0] CHAR_LF       = 8'h0A;
  localparam logic [ByteW-1:0] CHAR_ESC      = 8'h1B;
  localparam logic [ByteW-1:0] CHAR_SPACE    = 8'h20;
  localparam logic [ByteW-1:0] CHAR_LBRACKET = 8'h5B;
  localparam logic [ByteW-1:0] CHAR_RBRACKET = 8'h5D;
  localparam logic [ByteW-1:0] CSI_FINAL_LO  = 8'h40;
  localparam logic [ByteW-1:0] CSI_FINAL_HI  = 8'h7E;

  // matcher node is {tag, depth}; all ones means no tag in progress
  localparam logic [NodeW-1:0] NODE_IDLE = 6'h3F;
  localparam logic [NodeW-1:0] NODE_ROOT = 6'h00;

  // tag group bits
  localparam int unsigned GRP_ERROR   = 0;
  localparam int unsigned GRP_WARNING = 1;
  localparam int unsigned GRP_DEBUG   = 2;
  localparam int unsigned GRP_VERBOSE = 3;
  localparam int unsigned GRP_INFO    = 4;

  typedef enum logic [1:0] {
    ESC_NORMAL = 2'd0,
    ESC_SEEN   = 2'd1,
    ESC_CSI    = 2'd2
  } esc_mode_e;

  typedef enum logic [LevelW-1:0] {
    LVL_INFO    = 3'd0,
    LVL_WARNING = 3'd1,
    LVL_ERROR   = 3'd2,
    LVL_DEBUG   = 3'd3,
    LVL_VERBOSE = 3'd4
  } level_e;

  localparam logic [ByteW-1:0] TAG_BODY [NumTags][TagMaxW] = '{
    '{"E", "R", "R", "O", "R", 8'h00, 8'h00, 8'h00},
    '{"F", "A", "T", "A", "L", 8'h00, 8'h00, 8'h00},
    '{"W", "A", "R", "N", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"W", "A", "R", "N", "I", "N", "G", 8'h00},
    '{"D", "E", "B", "U", "G", 8'h00, 8'h00, 8'h00},
    '{"T", "R", "A", "C", "E", 8'h00, 8'h00, 8'h00},
    '{"V", "E", "R", "B", "O", "S", "E", 8'h00},
    '{"I", "N", "F", "O", 8'h00, 8'h00, 8'h00, 8'h00}
  };

  localparam logic [2:0] TAG_LEN [NumTags] = '{
    3'd5, 3'd5, 3'd4, 3'd7, 3'd5, 3'd5, 3'd7, 3'd4
  };

  localparam logic [2:0] TAG_GROUP [NumTags] = '{
    3'(GRP_ERROR), 3'(GRP_ERROR), 3'(GRP_WARNING), 3'(GRP_WARNING),
    3'(GRP_DEBUG), 3'(GRP_VERBOSE), 3'(GRP_VERBOSE), 3'(GRP_INFO)
  };

  typedef struct packed {
    logic [ByteW-1:0] in_byte;
    logic             end_of_text;
  } lsct_item_t;

  typedef struct packed {
    logic [ByteW-1:0]  out_byte;
    logic              byte_kept;
    logic              line_done;
    logic [LevelW-1:0] line_level;
    logic              new_block;
  } lsct_result_t;

  // first d characters of tag u equal those of tag t
  function automatic logic prefix_eq(logic [2:0] u, logic [2:0] t, logic [2:0] d);
    logic eq;
    eq = 1'b1;
    for (int i = 0; i < TagMaxW - 1; i++) begin
      if ((3'(i) < d) && (TAG_BODY[u][3'(i)] != TAG_BODY[t][3'(i)])) begin
        eq = 1'b0;
      end
    end
    return eq;
  endfunction

  // advance the matcher by one tag character, first matching tag wins
  function automatic logic [NodeW-1:0] step_node(logic [2:0] t, logic [2:0] d,
                                                 logic [ByteW-1:0] c);
    logic [NodeW-1:0] nxt;
    logic             found;
    nxt   = NODE_IDLE;
    found = 1'b0;
    for (int u = 0; u < NumTags; u++) begin
      if (!found && (TAG_LEN[3'(u)] > d) && prefix_eq(3'(u), t, d) &&
          (TAG_BODY[3'(u)][d] == c)) begin
        nxt   = {3'(u), 3'(d + 3'd1)};
        found = 1'b1;
      end
    end
    return nxt;
  endfunction

  // groups of every tag that is complete at this node
  function automatic logic [GroupW-1:0] close_mask(logic [2:0] t, logic [2:0] d);
    logic [GroupW-1:0] m;
    m = '0;
    for (int u = 0; u < NumTags; u++) begin
      if ((TAG_LEN[3'(u)] == d) && prefix_eq(3'(u), t, d)) begin
        m = m | (GroupW'(1) << TAG_GROUP[3'(u)]);
      end
    end
    return m;
  endfunction

endpackage

// ----- design/lsct_in_if.sv -----
// ----------------------------------------------------------------------------
// lsct_in_if
// raw byte channel: valid/ready with one log byte and an end of text mark
// ----------------------------------------------------------------------------
interface lsct_in_if import lsct_pkg::*; ();

  logic             valid;
  logic             ready;
  logic [ByteW-1:0] in_byte;
  logic             end_of_text;

  modport source (output valid, output in_byte, output end_of_text, input ready);
  modport sink   (input valid, input in_byte, input end_of_text, output ready);

endinterface

// ----- design/lsct_out_if.sv -----
// ----------------------------------------------------------------------------
// lsct_out_if
// result channel: valid/ready with kept byte and line level report
// ----------------------------------------------------------------------------
interface lsct_out_if import lsct_pkg::*; ();

  logic              valid;
  logic              ready;
  logic [ByteW-1:0]  out_byte;
  logic              byte_kept;
  logic              line_done;
  logic [LevelW-1:0] line_level;
  logic              new_block;

  modport source (output valid, output out_byte, output byte_kept, output line_done,
                  output line_level, output new_block, input ready);
  modport sink   (input valid, input out_byte, input byte_kept, input line_done,
                  input line_level, input new_block, output ready);

endinterface

// ----- design/lsct_in_reg.sv -----
// ----------------------------------------------------------------------------
// lsct_in_reg
// input register: holds one accepted request until the core consumes it
// ----------------------------------------------------------------------------
module lsct_in_reg import lsct_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  lsct_in_if.sink     in_i,
  input  logic        take_i,
  output logic        valid_o,
  output lsct_item_t  item_o
);

  logic       valid_q, valid_d;
  lsct_item_t item_q;
  logic       load;

  assign in_i.ready = !valid_q || take_i;
  assign load       = in_i.valid && in_i.ready;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (take_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      item_q <= '{in_byte: in_i.in_byte, end_of_text: in_i.end_of_text};
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

// ----- design/lsct_core.sv -----
// ----------------------------------------------------------------------------
// lsct_core
// escape stripping, tag matcher and line level state, one byte per cycle while take_i is high
// ----------------------------------------------------------------------------
module lsct_core import lsct_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         take_i,
  input  lsct_item_t   item_i,
  output logic         has_result_o,
  output lsct_result_t result_o
);

  esc_mode_e         esc_q, esc_d;
  logic [NodeW-1:0]  node_q, node_d;
  logic [GroupW-1:0] tags_q, tags_d;
  logic              has_q, has_d;
  level_e            level_q, level_d;
  logic              any_q, any_d;

  logic [ByteW-1:0]  c;
  logic              kept;
  logic              is_printable;
  logic [NodeW-1:0]  node_fed;
  logic [GroupW-1:0] tags_fed;
  logic [2:0]        tag_id;
  logic [2:0]        depth;
  logic              done;
  logic              fresh;
  level_e            level;

  assign c            = item_i.in_byte;
  assign is_printable = (c == CHAR_LF) || (c == CHAR_TAB) || (c >= CHAR_SPACE);
  assign tag_id       = node_q[NodeW-1:3];
  assign depth        = node_q[2:0];

  // escape handling
  always_comb begin
    esc_d = ESC_NORMAL;
    kept  = 1'b0;
    unique case (esc_q)
      ESC_CSI: begin
        esc_d = ((c >= CSI_FINAL_LO) && (c <= CSI_FINAL_HI)) ? ESC_NORMAL : ESC_CSI;
      end
      ESC_SEEN: begin
        if (c == CHAR_LBRACKET) begin
          esc_d = ESC_CSI;
        end else if (c == CHAR_ESC) begin
          esc_d = ESC_SEEN;
        end else begin
          kept = is_printable;
        end
      end
      default: begin
        if (c == CHAR_ESC) begin
          esc_d = ESC_SEEN;
        end else begin
          kept = is_printable;
        end
      end
    endcase
  end

  // tag matcher
  always_comb begin
    node_fed = node_q;
    tags_fed = tags_q;
    if (kept) begin
      priority if (c == CHAR_LBRACKET) begin
        node_fed = NODE_ROOT;
      end else if (node_q == NODE_IDLE) begin
        node_fed = NODE_IDLE;
      end else if (depth > TAG_LEN[tag_id]) begin
        node_fed = NODE_IDLE;
      end else if (c == CHAR_RBRACKET) begin
        tags_fed = tags_q | close_mask(tag_id, depth);
        node_fed = NODE_IDLE;
      end else begin
        node_fed = step_node(tag_id, depth, c);
      end
    end
  end

  // line level
  always_comb begin
    done  = (kept && (c == CHAR_LF)) || (item_i.end_of_text && (has_q || kept));
    level = level_q;
    priority if (tags_fed[GRP_ERROR]) begin
      level = LVL_ERROR;
    end else if (tags_fed[GRP_WARNING]) begin
      level = LVL_WARNING;
    end else if (tags_fed[GRP_DEBUG]) begin
      level = LVL_DEBUG;
    end else if (tags_fed[GRP_VERBOSE]) begin
      level = LVL_VERBOSE;
    end else if (tags_fed[GRP_INFO]) begin
      level = LVL_INFO;
    end else begin
      level = level_q;
    end
    fresh = !any_q || (level != level_q);
  end

  always_comb begin
    node_d  = node_fed;
    tags_d  = tags_fed;
    has_d   = has_q || kept;
    level_d = level_q;
    any_d   = any_q;
    if (done) begin
      level_d = level;
      any_d   = 1'b1;
      tags_d  = '0;
      has_d   = 1'b0;
      node_d  = NODE_IDLE;
    end
    // end of text starts the next text from scratch
    if (item_i.end_of_text) begin
      node_d  = NODE_IDLE;
      tags_d  = '0;
      has_d   = 1'b0;
      level_d = LVL_INFO;
      any_d   = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      esc_q   <= ESC_NORMAL;
      node_q  <= NODE_IDLE;
      tags_q  <= '0;
      has_q   <= 1'b0;
      level_q <= LVL_INFO;
      any_q   <= 1'b0;
    end else if (take_i) begin
      esc_q   <= item_i.end_of_text ? ESC_NORMAL : esc_d;
      node_q  <= node_d;
      tags_q  <= tags_d;
      has_q   <= has_d;
      level_q <= level_d;
      any_q   <= any_d;
    end
  end

  assign has_result_o        = kept || done;
  assign result_o.out_byte   = kept ? c : '0;
  assign result_o.byte_kept  = kept;
  assign result_o.line_done  = done;
  assign result_o.line_level = done ? LevelW'(level) : '0;
  assign result_o.new_block  = done && fresh;

endmodule

// ----- design/lsct_out_reg.sv -----
// ----------------------------------------------------------------------------
// lsct_out_reg
// result register: holds one result until the receiver takes it
// ----------------------------------------------------------------------------
module lsct_out_reg import lsct_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         take_i,
  input  logic         has_result_i,
  input  lsct_result_t result_i,
  output logic         can_take_o,
  lsct_out_if.source   out_o
);

  logic         valid_q, valid_d;
  lsct_result_t data_q;
  logic         load;

  assign can_take_o = !valid_q || out_o.ready;
  assign load       = take_i && has_result_i;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (out_o.ready) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      data_q <= result_i;
    end
  end

  assign out_o.valid      = valid_q;
  assign out_o.out_byte   = data_q.out_byte;
  assign out_o.byte_kept  = data_q.byte_kept;
  assign out_o.line_done  = data_q.line_done;
  assign out_o.line_level = data_q.line_level;
  assign out_o.new_block  = data_q.new_block;

endmodule

// ----- design/log_stream_clean_and_level_tag_unit.sv -----
// ----------------------------------------------------------------------------
// log_stream_clean_and_level_tag_unit
// strips ANSI CSI sequences and control bytes from log text and tags each
// line with its level
// ----------------------------------------------------------------------------
// in_i takes one raw byte per request, end_of_text set on the last byte of a
// text. out_o gives one result per request that keeps a byte or ends a line:
// the cleaned byte with byte_kept, and on line end line_done, line_level and
// new_block. Requests that are dropped whole (escapes, CR, other control bytes)
// give no result, unless they carry end_of_text while a line is open.
// Path: an accepted request passes the input register, then the cleaning and tag
// logic into the result register.
// Throughput: one request per cycle while out_o.ready stays high; the escape,
// matcher and line state update once for each request taken.
// Reset: asynchronous, active low; both channels go empty, no escape pending,
// level info, no block open.
// Stall: when out_o.ready is low the result register holds; while the input
// register holds a request not taken, in_i.ready is low; nothing is lost.
// ----------------------------------------------------------------------------
module log_stream_clean_and_level_tag_unit import lsct_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  lsct_in_if.sink    in_i,
  lsct_out_if.source out_o
);

  logic         item_valid;
  lsct_item_t   item;
  logic         can_take;
  logic         take;
  logic         has_result;
  lsct_result_t result;

  assign take = item_valid && can_take;

  lsct_in_reg u_in_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_i),
    .take_i  (take),
    .valid_o (item_valid),
    .item_o  (item)
  );

  lsct_core u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .take_i       (take),
    .item_i       (item),
    .has_result_o (has_result),
    .result_o     (result)
  );

  lsct_out_reg u_out_reg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .take_i       (take),
    .has_result_i (has_result),
    .result_i     (result),
    .can_take_o   (can_take),
    .out_o        (out_o)
  );

endmodule

// ----- design/lsct_checker.sv -----
// ----------------------------------------------------------------------------
// lsct_checker
// port level checks of the log clean and tag unit, bound to the top level
// ----------------------------------------------------------------------------
module lsct_checker import lsct_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              out_valid_i,
  input  logic              out_ready_i,
  input  logic [ByteW-1:0]  out_byte_i,
  input  logic              byte_kept_i,
  input  logic              line_done_i,
  input  logic [LevelW-1:0] line_level_i,
  input  logic              new_block_i
);

  // a stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_byte_i) &&
      $stable(byte_kept_i) && $stable(line_done_i) && $stable(line_level_i) &&
      $stable(new_block_i))
    else $error("result changed while stalled");

  // every result carries a byte or a line end
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> byte_kept_i || line_done_i)
    else $error("empty result");

  // no byte means a zero byte field
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !byte_kept_i |-> out_byte_i == '0)
    else $error("byte field set without kept byte");

  // level fields only on line end, and a level is one of five codes
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (line_done_i || (line_level_i == '0 && !new_block_i)) &&
      (line_level_i <= LevelW'(LVL_VERBOSE)))
    else $error("bad line level report");

endmodule

bind log_stream_clean_and_level_tag_unit lsct_checker u_lsct_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .out_byte_i   (out_o.out_byte),
  .byte_kept_i  (out_o.byte_kept),
  .line_done_i  (out_o.line_done),
  .line_level_i (out_o.line_level),
  .new_block_i  (out_o.new_block)
);
